/* src/sise_pkg.sv */
package sise_pkg;

   typedef enum logic [1:0] {
      REQ_CONTAINS = 2'd0,
      REQ_INSERT   = 2'd1,
      REQ_REMOVE   = 2'd2,
      REQ_READ     = 2'd3
   } req_kind_type;

   typedef enum logic [1:0] {
      ST_DONE      = 2'd0,
      ST_NO_CHANGE = 2'd1,
      ST_FULL      = 2'd2,
      ST_BAD_POS   = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      WC_16 = 2'd0,
      WC_32 = 2'd1,
      WC_64 = 2'd2
   } width_class_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SEARCH_RD,
      S_SEARCH_CMP,
      S_CHECK_RD,
      S_CHECK_CMP,
      S_DECIDE,
      S_SHIFT_RD,
      S_SHIFT_WR,
      S_STORE,
      S_POS_RD,
      S_POS_WAIT,
      S_RESPOND
   } state_type;

   function automatic width_class_type class_of(input logic signed [63:0] v);
      logic hi32_ok;
      logic hi16_ok;
      hi32_ok = (v[63:31] == '0) || (v[63:31] == '1);
      hi16_ok = (v[63:15] == '0) || (v[63:15] == '1);
      if (!hi32_ok) begin
         return WC_64;
      end else if (!hi16_ok) begin
         return WC_32;
      end
      return WC_16;
   endfunction

endpackage

/* src/sise_ram.sv */
module sise_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

/* src/sorted_integer_set_engine_core.sv */
// Sorted set of distinct signed 64-bit integers held in one synchronous RAM.
// Command channel: a transaction is taken when start is high and busy is low;
// req_type selects contains, insert, remove or read by position.
// Every transaction yields exactly one result on the rsp_ ports, marked by
// done for one cycle; the receiver cannot hold it off.
// Steps: a lower-bound binary search whose halving steps are each a RAM read
// state then a compare state, none on an empty set; then a check read, compared
// when the slot is below the count; a decide state; and the response state. An
// insert that adds or a remove that finds its value moves entries one at a time
// (a read state then a write state per entry moved), then passes a store state.
// Reads by position add a read state and a wait state.
// busy is high from acceptance through the response cycle; the next transaction
// can be accepted in the cycle after done.
// Reset clears the count and width class; the RAM needs no clearing since
// only entries below the count are ever used.
// The width class rises when an insert stores a value wider than the class
// and never falls.
module sorted_integer_set_engine_core
   import sise_pkg::*;
#(
   parameter int CAPACITY = 256
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic [1:0]               req_type,
   input  logic signed [63:0]       req_value,
   input  logic [7:0]               req_position,
   output logic                     done,
   output logic [1:0]               rsp_status,
   output logic                     rsp_found,
   output logic [8:0]               rsp_slot,
   output logic signed [63:0]       rsp_read_value,
   output logic [8:0]               rsp_count,
   output logic [1:0]               rsp_width_class
);

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);

   state_type state_ff, state_in;

   logic [1:0]          kind_ff;
   logic signed [63:0]  val_ff;
   logic [7:0]          pos_ff;
   logic [CW-1:0]       lo_ff, lo_in, hi_ff, hi_in;
   logic [CW-1:0]       cnt_ff, cnt_in;
   logic [CW-1:0]       idx_ff, idx_in;
   logic [1:0]          wc_ff, wc_in;
   logic                found_ff, found_in;
   logic [1:0]          status_ff, status_in;
   logic signed [63:0]  rd_ff, rd_in;

   logic                ram_we;
   logic [AW-1:0]       ram_wa, ram_ra;
   logic [63:0]         ram_wd, ram_rd;
   logic [CW-1:0]       mid;

   assign mid = lo_ff + ((hi_ff - lo_ff) >> 1);

   sise_ram #(.WIDTH(64), .DEPTH(CAPACITY)) u_ram (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(ram_wa),
      .wr_data(ram_wd),
      .rd_addr(ram_ra),
      .rd_data(ram_rd)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:       if (start) state_in = (cnt_ff == '0) ? S_DECIDE : S_SEARCH_RD;
         S_SEARCH_RD:  state_in = S_SEARCH_CMP;
         S_SEARCH_CMP: state_in = (lo_in < hi_in) ? S_SEARCH_RD : S_CHECK_RD;
         S_CHECK_RD:   state_in = (lo_ff < cnt_ff) ? S_CHECK_CMP : S_DECIDE;
         S_CHECK_CMP:  state_in = S_DECIDE;
         S_DECIDE: begin
            state_in = S_RESPOND;
            unique case (kind_ff)
               REQ_INSERT: if (!found_ff && cnt_ff < CW'(CAPACITY))
                  state_in = (idx_in > lo_ff) ? S_SHIFT_RD : S_STORE;
               REQ_REMOVE: if (found_ff)
                  state_in = (idx_in + 1'b1 < cnt_ff) ? S_SHIFT_RD : S_STORE;
               REQ_READ:   if (CW'(pos_ff) < cnt_ff) state_in = S_POS_RD;
               default:    state_in = S_RESPOND;
            endcase
         end
         S_SHIFT_RD:   state_in = S_SHIFT_WR;
         S_SHIFT_WR: begin
            if (kind_ff == REQ_INSERT) begin
               state_in = (idx_ff - 1'b1 > lo_ff) ? S_SHIFT_RD : S_STORE;
            end else begin
               state_in = (idx_ff + 2'd2 < cnt_ff) ? S_SHIFT_RD : S_STORE;
            end
         end
         S_STORE:      state_in = S_RESPOND;
         S_POS_RD:     state_in = S_POS_WAIT;
         S_POS_WAIT:   state_in = S_RESPOND;
         S_RESPOND:    state_in = S_IDLE;
         default:      state_in = S_IDLE;
      endcase
   end

   // Datapath and memory control.
   always_comb begin
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      cnt_in    = cnt_ff;
      idx_in    = idx_ff;
      wc_in     = wc_ff;
      found_in  = found_ff;
      status_in = status_ff;
      rd_in     = rd_ff;
      ram_we    = 1'b0;
      ram_wa    = idx_ff[AW-1:0];
      ram_wd    = val_ff;
      ram_ra    = mid[AW-1:0];
      unique case (state_ff)
         S_IDLE: begin
            lo_in     = '0;
            hi_in     = cnt_ff;
            found_in  = 1'b0;
            status_in = ST_DONE;
            rd_in     = '0;
         end
         S_SEARCH_RD: ram_ra = mid[AW-1:0];
         S_SEARCH_CMP: begin
            if ($signed(ram_rd) < val_ff) lo_in = mid + 1'b1;
            else hi_in = mid;
         end
         S_CHECK_RD: ram_ra = lo_ff[AW-1:0];
         S_CHECK_CMP: found_in = ($signed(ram_rd) == val_ff);
         S_DECIDE: begin
            unique case (kind_ff)
               REQ_INSERT: begin
                  idx_in = cnt_ff;
                  if (found_ff) status_in = ST_NO_CHANGE;
                  else if (cnt_ff >= CW'(CAPACITY)) status_in = ST_FULL;
               end
               REQ_REMOVE: begin
                  idx_in = lo_ff;
                  if (!found_ff) status_in = ST_NO_CHANGE;
               end
               REQ_READ: if (CW'(pos_ff) >= cnt_ff) status_in = ST_BAD_POS;
               default: status_in = ST_DONE;
            endcase
         end
         S_SHIFT_RD: begin
            // Insert moves entry idx-1 up to idx; remove moves idx+1 down to idx.
            if (kind_ff == REQ_INSERT) ram_ra = AW'(idx_ff - 1'b1);
            else ram_ra = AW'(idx_ff + 1'b1);
         end
         S_SHIFT_WR: begin
            ram_we = 1'b1;
            ram_wa = idx_ff[AW-1:0];
            ram_wd = ram_rd;
            if (kind_ff == REQ_INSERT) idx_in = idx_ff - 1'b1;
            else idx_in = idx_ff + 1'b1;
         end
         S_STORE: begin
            if (kind_ff == REQ_INSERT) begin
               ram_we = 1'b1;
               ram_wa = lo_ff[AW-1:0];
               ram_wd = val_ff;
               cnt_in = cnt_ff + 1'b1;
               if (class_of(val_ff) > wc_ff) wc_in = class_of(val_ff);
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         S_POS_RD: ram_ra = AW'(pos_ff);
         S_POS_WAIT: rd_in = ram_rd;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
         wc_ff    <= WC_16;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         wc_ff    <= wc_in;
      end
      if (state_ff == S_IDLE && start) begin
         kind_ff <= req_type;
         val_ff  <= req_value;
         pos_ff  <= req_position;
      end
      lo_ff     <= lo_in;
      hi_ff     <= hi_in;
      idx_ff    <= idx_in;
      found_ff  <= found_in;
      status_ff <= status_in;
      rd_ff     <= rd_in;
   end

   // Outputs.
   always_comb begin
      busy            = (state_ff != S_IDLE);
      done            = (state_ff == S_RESPOND);
      rsp_status      = status_ff;
      rsp_found       = found_ff;
      rsp_slot        = 9'(lo_ff);
      rsp_read_value  = rd_ff;
      rsp_count       = 9'(cnt_ff);
      rsp_width_class = wc_ff;
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(CAPACITY)) else $error("entry count above capacity");
   a_wc_monotone: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> wc_ff >= $past(wc_ff)) else $error("width class fell");
   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      done |=> !done) else $error("done held longer than one cycle");
   a_search_bounds: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_CHECK_RD |-> lo_ff <= cnt_ff) else $error("slot beyond count");

endmodule
